@@ design/pdc_pkg.sv @@
package pdc_pkg;

   localparam int unsigned CHANNEL_ID = 1;
   localparam logic [2:0]  CHAN_POS   = 3'(CHANNEL_ID - 1);
   localparam logic [7:0]  CHAN_ID_BYTE = 8'(CHANNEL_ID);

   localparam logic [7:0] FULL_SCALE_RESET = 8'd250;
   localparam logic [7:0] BCAST_RESET      = 8'hFF;

   localparam logic [7:0] STATUS_QUERY   = 8'hFF;
   localparam logic [7:0] SW_CODE_MASK   = 8'h03;
   localparam logic [7:0] SW_CODE_TOGGLE = 8'h02;
   localparam logic [7:0] REMOTE_PROTO   = 8'h00;
   localparam logic [7:0] REMOTE_DEVICE  = 8'h02;
   localparam logic [7:0] KEY_OFF        = 8'h12;
   localparam logic [7:0] KEY_THIRD      = 8'h92;
   localparam logic [7:0] KEY_TWO_THIRDS = 8'h52;
   localparam logic [7:0] KEY_ON         = 8'hD2;
   localparam logic [7:0] TICK_MAX       = 8'hFF;

   localparam logic [1:0] LEN_SWITCH = 2'd1;
   localparam logic [1:0] LEN_DIMMER = 2'd3;

   // configuration register indexes
   localparam logic [0:0] CSR_FULL_SCALE = 1'b0;
   localparam logic [0:0] CSR_BCAST      = 1'b1;

   typedef enum logic [1:0] {
      OP_MESSAGE = 2'd0,
      OP_SAMPLE  = 2'd1,
      OP_TICK    = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SWITCH = 2'd0,
      KIND_DIMMER = 2'd1,
      KIND_REMOTE = 2'd2,
      KIND_OTHER  = 2'd3
   } msg_kind_type;

   typedef enum logic [0:0] {
      REPLY_SWITCH = 1'b0,
      REPLY_DIMMER = 1'b1
   } reply_kind_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] message_kind;
      logic [7:0] source_address;
      logic [7:0] message_size;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic       detector_level;
   } req_type;

   typedef struct packed {
      logic       relay_on;
      logic       light_on;
      logic       reply_valid;
      logic       reply_kind;
      logic [7:0] reply_address;
      logic [1:0] reply_length;
      logic [7:0] reply_byte0;
      logic [7:0] reply_byte1;
      logic [7:0] reply_byte2;
   } rsp_type;

   typedef struct packed {
      logic       light;
      logic [7:0] dim_level;
      logic       armed;
      logic       timer_run;
      logic       awaited;
      logic [7:0] tick_count;
      logic       relay;
   } state_type;

   // x/3 for 8-bit x via reciprocal multiply
   function automatic logic [7:0] div3_8(input logic [7:0] x);
      logic [15:0] prod;
      prod = 16'(x) * 16'd171;
      return {1'b0, prod[15:9]};
   endfunction

   // (2x)/3 for 8-bit x
   function automatic logic [7:0] two_thirds_8(input logic [7:0] x);
      logic [18:0] prod;
      prod = 19'({x, 1'b0}) * 19'd683;
      return prod[18:11];
   endfunction

endpackage

@@ design/phase_angle_dimmer_controller_top.sv @@
// a request beat passes the input register, then the result register, before
// its response beat appears
// throughput: one beat per cycle; while a response waits, the input register
// takes at most one more beat before the request side stalls
// reset: synchronous, active high; clears the light, dimmer and phase state and
// restores full scale 250 and broadcast address 255
module phase_angle_dimmer_controller_top import pdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // source_address, message_size, first_byte, second_byte, third_byte,
   // detector_level, zero fill
   input  logic [47:0] req_tdata,
   // opcode, message_kind
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // relay_on, light_on, reply_address, reply_length, reply_byte0,
   // reply_byte1, reply_byte2, zero fill
   output logic [39:0] rsp_tdata,
   // reply_valid, reply_kind
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0] full_scale_ff, full_scale_in;
   logic [7:0] bcast_ff, bcast_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   req_type    req_item;
   req_type    item;
   rsp_type    result;
   logic       item_valid;
   logic       advance;

   assign req_item.opcode         = req_tuser[1:0];
   assign req_item.message_kind   = req_tuser[3:2];
   assign req_item.source_address = req_tdata[7:0];
   assign req_item.message_size   = req_tdata[15:8];
   assign req_item.first_byte     = req_tdata[23:16];
   assign req_item.second_byte    = req_tdata[31:24];
   assign req_item.third_byte     = req_tdata[39:32];
   assign req_item.detector_level = req_tdata[40];

   assign advance = item_valid && (!out_valid_ff || rsp_tready);

   pdc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (item),
      .full_scale (full_scale_ff),
      .bcast_addr (bcast_ff),
      .result     (result)
   );

   always_comb begin
      full_scale_in = full_scale_ff;
      bcast_in      = bcast_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FULL_SCALE: full_scale_in = csr_wdata;
            CSR_BCAST:      bcast_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RESET;
         bcast_ff      <= BCAST_RESET;
         out_valid_ff  <= 1'b0;
      end else begin
         full_scale_ff <= full_scale_in;
         bcast_ff      <= bcast_in;
         out_valid_ff  <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.reply_byte2, out_ff.reply_byte1, out_ff.reply_byte0,
                        out_ff.reply_length, out_ff.reply_address,
                        out_ff.light_on, out_ff.relay_on};
   assign rsp_tuser  = {out_ff.reply_kind, out_ff.reply_valid};

endmodule

@@ design/pdc_input_stage.sv @@
module pdc_input_stage import pdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  req_type    req_item,
   input  logic       advance,
   output logic       item_valid,
   output req_type    item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         if (req_tvalid) begin
            item_in = req_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ design/pdc_ctrl.sv @@
module pdc_ctrl import pdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  req_type    item,
   input  logic [7:0] full_scale,
   input  logic [7:0] bcast_addr,
   output rsp_type    result
);

   state_type st_ff, st_in;

   logic [7:0] third_lvl;
   logic [7:0] two_third_lvl;
   logic [7:0] tick_next;
   logic [9:0] fire_margin;

   assign third_lvl     = div3_8(full_scale);
   assign two_third_lvl = two_thirds_8(full_scale);
   assign tick_next     = (st_ff.tick_count == TICK_MAX) ? TICK_MAX : st_ff.tick_count + 8'd1;
   assign fire_margin   = {2'b00, full_scale} - {2'b00, st_ff.dim_level};

   always_comb begin
      logic       sw_apply;
      logic       sw_light;
      logic       dim_apply;
      logic [7:0] dim_value;
      logic       reply;
      logic       reply_dim;
      logic [7:0] reply_addr;

      sw_apply   = 1'b0;
      sw_light   = 1'b0;
      dim_apply  = 1'b0;
      dim_value  = 8'd0;
      reply      = 1'b0;
      reply_dim  = 1'b0;
      reply_addr = item.source_address;
      st_in      = st_ff;

      case (opcode_type'(item.opcode))
         OP_MESSAGE: begin
            case (msg_kind_type'(item.message_kind))
               KIND_SWITCH: begin
                  if (item.message_size == 8'd1 && item.first_byte == STATUS_QUERY) begin
                     reply = 1'b1;
                  end else if (item.message_size == 8'd2) begin
                     if (item.first_byte <= SW_CODE_TOGGLE) begin
                        reply = 1'b1;
                        if (item.second_byte == CHAN_ID_BYTE) begin
                           sw_apply = 1'b1;
                           case (item.first_byte[1:0])
                              2'd0:    sw_light = 1'b0;
                              2'd1:    sw_light = 1'b1;
                              default: sw_light = !st_ff.light;
                           endcase
                        end
                     end else if (item.first_byte == SW_CODE_MASK) begin
                        reply    = 1'b1;
                        sw_apply = 1'b1;
                        sw_light = item.second_byte[CHAN_POS];
                     end
                  end
               end
               KIND_DIMMER: begin
                  if (item.message_size == 8'd1 && item.first_byte == STATUS_QUERY) begin
                     reply     = 1'b1;
                     reply_dim = 1'b1;
                  end else if (item.message_size == 8'd2 && item.first_byte[CHAN_POS]
                               && item.second_byte <= full_scale) begin
                     reply     = 1'b1;
                     reply_dim = 1'b1;
                     dim_apply = 1'b1;
                     dim_value = item.second_byte;
                  end
               end
               KIND_REMOTE: begin
                  if (item.first_byte == REMOTE_PROTO && item.second_byte == REMOTE_DEVICE) begin
                     reply_addr = bcast_addr;
                     case (item.third_byte)
                        KEY_OFF: begin
                           reply    = 1'b1;
                           sw_apply = 1'b1;
                           sw_light = 1'b0;
                        end
                        KEY_ON: begin
                           reply    = 1'b1;
                           sw_apply = 1'b1;
                           sw_light = 1'b1;
                        end
                        KEY_THIRD: begin
                           reply     = 1'b1;
                           reply_dim = 1'b1;
                           dim_apply = 1'b1;
                           dim_value = third_lvl;
                        end
                        KEY_TWO_THIRDS: begin
                           reply     = 1'b1;
                           reply_dim = 1'b1;
                           dim_apply = 1'b1;
                           dim_value = two_third_lvl;
                        end
                        default: ;
                     endcase
                  end
               end
               default: ;
            endcase
         end
         OP_SAMPLE: begin
            if (st_ff.armed && item.detector_level == st_ff.awaited) begin
               if (st_ff.awaited) begin
                  st_in.timer_run = 1'b0;
                  st_in.relay     = 1'b0;
               end else begin
                  st_in.timer_run = 1'b1;
               end
               st_in.tick_count = 8'd0;
               st_in.awaited    = !st_ff.awaited;
            end
         end
         OP_TICK: begin
            if (st_ff.timer_run) begin
               st_in.tick_count = tick_next;
               // signed compare: a level above a lowered full scale fires at once
               if ($signed(fire_margin) < $signed({2'b00, tick_next})) begin
                  st_in.relay = 1'b1;
               end
            end
         end
         default: ;
      endcase

      // static relay mode
      if (sw_apply) begin
         st_in.light     = sw_light;
         st_in.armed     = 1'b0;
         st_in.timer_run = 1'b0;
         st_in.relay     = sw_light;
      end

      if (dim_apply) begin
         st_in.dim_level = dim_value;
         st_in.light     = (dim_value != 8'd0);
         if (dim_value != 8'd0) begin
            st_in.armed = 1'b1;
         end else begin
            st_in.armed     = 1'b0;
            st_in.timer_run = 1'b0;
            st_in.relay     = 1'b0;
         end
      end

      result               = '0;
      result.relay_on      = st_in.relay;
      result.light_on      = st_in.light;
      result.reply_valid   = reply;
      if (reply) begin
         result.reply_address = reply_addr;
         if (reply_dim) begin
            result.reply_kind   = REPLY_DIMMER;
            result.reply_length = LEN_DIMMER;
            result.reply_byte0  = 8'd1;
            result.reply_byte1  = CHAN_ID_BYTE;
            result.reply_byte2  = st_in.dim_level;
         end else begin
            result.reply_kind   = REPLY_SWITCH;
            result.reply_length = LEN_SWITCH;
            result.reply_byte0  = 8'(st_in.light) << CHAN_POS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

endmodule
